### rtl/core/sorted_unique_key_table_defines.svh
// Assertion helpers for the key table RTL.
`ifndef SORTED_UNIQUE_KEY_TABLE_DEFINES_SVH
`define SORTED_UNIQUE_KEY_TABLE_DEFINES_SVH

// Property that must hold on every clock edge out of reset.
`define SUKT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("key table check failed");

// Condition in one cycle implies a condition in the next.
`define SUKT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("key table sequence check failed");

`endif

### rtl/core/sukt_pkg.sv
`default_nettype none
package sukt_pkg;

    localparam int KEY_W  = 17;
    localparam int CNT_W  = 7;
    localparam int GRP_W  = 7;
    localparam int MODE_W = 3;
    localparam int ST_W   = 4;

    localparam int DEF_CAPACITY = 64;

    localparam logic [KEY_W-1:0] KEY_MIN    = KEY_W'(10000);
    localparam logic [KEY_W-1:0] KEY_MAX    = KEY_W'(99999);
    localparam logic [GRP_W-1:0] GROUP_MIN  = GRP_W'(10);
    localparam logic [GRP_W-1:0] GROUP_MAX  = GRP_W'(99);
    localparam logic [KEY_W-1:0] GROUP_DIV  = KEY_W'(1000);
    localparam logic [KEY_W-1:0] GROUP_SPAN = KEY_W'(999);

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 3'd0,
        MODE_DELETE = 3'd1,
        MODE_SEARCH = 3'd2,
        MODE_GROUP  = 3'd3,
        MODE_DUMP   = 3'd4
    } t_mode;

    typedef enum logic [ST_W-1:0] {
        ST_INSERTED   = 4'd0,
        ST_DUPLICATE  = 4'd1,
        ST_FULL       = 4'd2,
        ST_DELETED    = 4'd3,
        ST_NOT_FOUND  = 4'd4,
        ST_FOUND      = 4'd5,
        ST_INVALID    = 4'd6,
        ST_ENTRY      = 4'd7,
        ST_NO_ENTRIES = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } t_cell_op;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        t_cell_op          op;
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  count;
    } t_cell_ctrl;

endpackage
`default_nettype wire

### rtl/core/sukt_cell.sv
`default_nettype none
module sukt_cell #(
    parameter int IDX = 0
) (
    input  wire logic                      i_clk,
    input  wire sukt_pkg::t_cell_ctrl      i_ctrl,
    input  wire logic [sukt_pkg::KEY_W-1:0] i_left_key,
    input  wire logic                      i_left_gt,
    input  wire logic [sukt_pkg::KEY_W-1:0] i_right_key,
    input  wire logic [sukt_pkg::KEY_W-1:0] i_head_key,
    output logic [sukt_pkg::KEY_W-1:0]      o_key,
    output logic                           o_gt,
    output logic                           o_eq
);
    import sukt_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;
    logic             occ;
    logic             ge;
    logic             first_free;
    logic             tail;

    assign occ        = CNT_W'(IDX) < i_ctrl.count;
    assign first_free = CNT_W'(IDX) == i_ctrl.count;
    assign tail       = CNT_W'(IDX + 1) == i_ctrl.count;
    assign o_gt       = occ && (r_key > i_ctrl.key);
    assign o_eq       = occ && (r_key == i_ctrl.key);
    assign ge         = occ && (r_key >= i_ctrl.key);
    assign o_key      = r_key;

    always_comb begin
        n_key = r_key;
        case (i_ctrl.op)
            CELL_INSERT: begin
                // larger keys move right by one, new key drops into the gap
                if (i_left_gt) begin
                    n_key = i_left_key;
                end else if (o_gt || first_free) begin
                    n_key = i_ctrl.key;
                end
            end
            CELL_DELETE: begin
                if (ge) begin
                    n_key = i_right_key;
                end
            end
            CELL_ROTATE: begin
                if (tail) begin
                    n_key = i_head_key;
                end else if (occ) begin
                    n_key = i_right_key;
                end
            end
            default: begin
                n_key = r_key;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule
`default_nettype wire

### rtl/core/sorted_unique_key_table.sv
// Sorted unique key table. Holds up to CAPACITY distinct keys (10000..99999)
// in ascending order in a chain of cells, one key per cell, each cell
// comparing its key against the broadcast key and trading keys with its
// neighbors. Insert, delete and search each give one registered result
// beat; a new beat is taken every cycle as long as the output beat is
// taken. Group query and dump list matching keys by rotating the chain
// past cell 0: a listing steps once per held key plus once to close,
// holding while an output beat waits, and gives one beat per match with
// o_last on the final one, or a single no-entries beat. Out-of-range
// insert keys, out-of-range groups and unknown modes answer with an
// invalid-range beat. Every beat carries the fill after the operation. The
// key store has no reset; the fill count alone marks which cells hold keys.
`default_nettype none
module sorted_unique_key_table #(
    parameter int CAPACITY = sukt_pkg::DEF_CAPACITY
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [sukt_pkg::MODE_W-1:0] i_mode,
    input  wire logic [sukt_pkg::KEY_W-1:0]  i_key,
    input  wire logic [sukt_pkg::GRP_W-1:0]  i_group,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [sukt_pkg::ST_W-1:0]        o_status,
    output logic [sukt_pkg::KEY_W-1:0]       o_entry,
    output logic [sukt_pkg::CNT_W-1:0]       o_fill,
    output logic                             o_last
);
    import sukt_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } t_state;

    // chain wiring
    t_cell_ctrl       cell_ctrl;
    logic [KEY_W-1:0] w_key [CAPACITY];
    logic             w_gt  [CAPACITY];
    logic [CAPACITY-1:0] w_eq;

    // control and output state
    t_state           r_state,  n_state;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             r_out_valid, n_out_valid;
    t_status          r_status, n_status;
    logic [KEY_W-1:0] r_entry,  n_entry;
    logic [CNT_W-1:0] r_fill,   n_fill;
    logic             r_last,   n_last;

    // listing state
    logic [CNT_W-1:0] r_left,   n_left;
    logic             r_dump,   n_dump;
    logic [KEY_W-1:0] r_lo,     n_lo;
    logic [KEY_W-1:0] r_hi,     n_hi;
    logic             r_pend,   n_pend;
    logic [KEY_W-1:0] r_pend_key, n_pend_key;

    logic out_free;
    logic in_acc;
    logic key_ok;
    logic grp_ok;
    logic any_eq;
    logic full;
    logic ins_ok;
    logic del_ok;
    logic list_step;
    logic head_match;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign key_ok     = (i_key >= KEY_MIN) && (i_key <= KEY_MAX);
    assign grp_ok     = (i_group >= GROUP_MIN) && (i_group <= GROUP_MAX);
    assign any_eq     = |w_eq;
    assign full       = r_count >= CNT_W'(CAPACITY);
    assign ins_ok     = in_acc && (i_mode == MODE_INSERT) && key_ok && !any_eq && !full;
    assign del_ok     = in_acc && (i_mode == MODE_DELETE) && any_eq;
    assign list_step  = (r_state == S_LIST) && out_free;
    // group match: key / 1000 == group  <=>  lo <= key <= lo + 999
    assign head_match = r_dump || ((w_key[0] >= r_lo) && (w_key[0] <= r_hi));

    always_comb begin
        cell_ctrl.key   = i_key;
        cell_ctrl.count = r_count;
        cell_ctrl.op    = CELL_HOLD;
        if (ins_ok) begin
            cell_ctrl.op = CELL_INSERT;
        end else if (del_ok) begin
            cell_ctrl.op = CELL_DELETE;
        end else if (list_step && (r_left != '0)) begin
            cell_ctrl.op = CELL_ROTATE;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_W-1:0] left_key;
        logic             left_gt;
        logic [KEY_W-1:0] right_key;

        if (g == 0) begin : g_first
            assign left_key = '0;
            assign left_gt  = 1'b0;
        end else begin : g_mid
            assign left_key = w_key[g-1];
            assign left_gt  = w_gt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign right_key = w_key[g];
        end else begin : g_inner
            assign right_key = w_key[g+1];
        end

        sukt_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (cell_ctrl),
            .i_left_key  (left_key),
            .i_left_gt   (left_gt),
            .i_right_key (right_key),
            .i_head_key  (w_key[0]),
            .o_key       (w_key[g]),
            .o_gt        (w_gt[g]),
            .o_eq        (w_eq[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_entry     = r_entry;
        n_fill      = r_fill;
        n_last      = r_last;
        n_left      = r_left;
        n_dump      = r_dump;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_pend      = r_pend;
        n_pend_key  = r_pend_key;

        if (in_acc) begin
            // single-beat answers by default
            n_out_valid = 1'b1;
            n_entry     = '0;
            n_last      = 1'b1;
            n_fill      = r_count;
            n_status    = ST_INVALID;
            case (i_mode)
                MODE_INSERT: begin
                    if (!key_ok) begin
                        n_status = ST_INVALID;
                    end else if (any_eq) begin
                        n_status = ST_DUPLICATE;
                    end else if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status = ST_INSERTED;
                        n_count  = r_count + CNT_W'(1);
                        n_fill   = r_count + CNT_W'(1);
                    end
                end
                MODE_DELETE: begin
                    if (any_eq) begin
                        n_status = ST_DELETED;
                        n_count  = r_count - CNT_W'(1);
                        n_fill   = r_count - CNT_W'(1);
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
                MODE_SEARCH: begin
                    n_status = any_eq ? ST_FOUND : ST_NOT_FOUND;
                end
                MODE_GROUP, MODE_DUMP: begin
                    if ((i_mode == MODE_DUMP) || grp_ok) begin
                        n_out_valid = 1'b0;
                        n_state     = S_LIST;
                        n_left      = r_count;
                        n_dump      = (i_mode == MODE_DUMP);
                        n_lo        = KEY_W'(KEY_W'(i_group) * GROUP_DIV);
                        n_hi        = KEY_W'(KEY_W'(i_group) * GROUP_DIV) + GROUP_SPAN;
                        n_pend      = 1'b0;
                    end
                end
                default: begin
                    n_status = ST_INVALID;
                end
            endcase
        end else if (list_step) begin
            if (r_left != '0) begin
                n_left = r_left - CNT_W'(1);
                if (head_match) begin
                    // a new match proves the held one is not the final beat
                    if (r_pend) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_ENTRY;
                        n_entry     = r_pend_key;
                        n_fill      = r_count;
                        n_last      = 1'b0;
                    end
                    n_pend     = 1'b1;
                    n_pend_key = w_key[0];
                end
            end else begin
                n_out_valid = 1'b1;
                n_fill      = r_count;
                n_last      = 1'b1;
                n_state     = S_IDLE;
                if (r_pend) begin
                    n_status = ST_ENTRY;
                    n_entry  = r_pend_key;
                end else begin
                    n_status = ST_NO_ENTRIES;
                    n_entry  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
        r_status   <= n_status;
        r_entry    <= n_entry;
        r_fill     <= n_fill;
        r_last     <= n_last;
        r_left     <= n_left;
        r_dump     <= n_dump;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_pend_key <= n_pend_key;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_entry     = r_entry;
    assign o_fill      = r_fill;
    assign o_last      = r_last;

`include "sorted_unique_key_table_defines.svh"

    `SUKT_ASSERT(a_count_cap, r_count <= CNT_W'(CAPACITY))
    `SUKT_ASSERT_NEXT(a_ins_count, ins_ok, r_count == $past(r_count) + CNT_W'(1))
    `SUKT_ASSERT_NEXT(a_del_count, del_ok, r_count == $past(r_count) - CNT_W'(1))
    `SUKT_ASSERT(a_entry_zero, !r_out_valid || (r_status == ST_ENTRY) || (r_entry == '0))
    `SUKT_ASSERT_NEXT(a_list_close, list_step && (r_left == '0), o_out_valid && o_last)

endmodule
`default_nettype wire
